FILE: rtl/core/ewfj_pkg.sv
package ewfj_pkg;

    // Default word format: signed Q24.24 in 48 bits
    localparam int WORD_BITS_DEF = 48;
    localparam int FRAC_BITS_DEF = 24;

    // Width of the ratio of specific heats register
    localparam int GAMMA_BITS = 26;

    // Equation rows of one result group
    localparam logic [1:0] ROW_MASS   = 2'd0;
    localparam logic [1:0] ROW_MOM_X  = 2'd1;
    localparam logic [1:0] ROW_MOM_Y  = 2'd2;
    localparam logic [1:0] ROW_ENERGY = 2'd3;

    // Pipeline depth of the multiplier bank
    localparam int MUL_STAGES = 3;

endpackage

FILE: rtl/core/ewfj_mul.sv
// Bank of saturating fixed-point multipliers, three register stages.
// Each lane splits its operands into halves so no partial product is
// wider than 24x24 by default. A side payload travels with the lanes.
module ewfj_mul #(
    parameter int W     = ewfj_pkg::WORD_BITS_DEF,
    parameter int F     = ewfj_pkg::FRAC_BITS_DEF,
    parameter int LANES = 1,
    parameter int SB    = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [LANES*W-1:0] a,
    input  logic [LANES*W-1:0] b,
    input  logic [SB-1:0]      side_in,
    output logic               out_valid,
    output logic [LANES*W-1:0] p,
    output logic [SB-1:0]      side_out
);

    localparam int H  = (W + 1) / 2;
    localparam int HW = W - H;
    localparam int PW = 2 * W;
    localparam logic [PW:0] ONE_P = 1;
    localparam logic [PW:0] RND   = ONE_P << (F - 1);
    localparam logic [PW:0] LIM_P = (ONE_P << (W - 1)) - ONE_P;
    localparam logic [PW:0] LIM_N = ONE_P << (W - 1);

    logic [2:0]    vld_reg;
    logic [SB-1:0] side_reg [0:2];

    // valid and side payload shift with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
        end
    end

    assign out_valid = vld_reg[2];
    assign side_out  = side_reg[2];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [W-1:0]    aw, bw, am, bm;
        logic [2*H-1:0]  ll_next;
        logic [W-1:0]    lh_next, hl_next;
        logic [2*HW-1:0] hh_next;
        logic [2*H-1:0]  ll_reg;
        logic [W-1:0]    lh_reg, hl_reg;
        logic [2*HW-1:0] hh_reg;
        logic [1:0]      neg_reg;
        logic [PW-1:0]   prod_next, prod_reg;
        logic [PW:0]     rs, sh, lim, m, mneg;
        logic [W-1:0]    p_next, p_reg;

        // stage 1: magnitudes and partial products
        assign aw = a[l*W +: W];
        assign bw = b[l*W +: W];
        assign am = aw[W-1] ? (~aw + 1'b1) : aw;
        assign bm = bw[W-1] ? (~bw + 1'b1) : bw;
        assign ll_next = am[H-1:0] * bm[H-1:0];
        assign lh_next = am[H-1:0] * bm[W-1:H];
        assign hl_next = am[W-1:H] * bm[H-1:0];
        assign hh_next = am[W-1:H] * bm[W-1:H];

        // stage 2: sum of partial products
        assign prod_next = PW'(ll_reg) + (PW'(lh_reg) << H) + (PW'(hl_reg) << H)
                         + (PW'(hh_reg) << (2 * H));

        // stage 3: round half away, scale, saturate, sign
        assign rs     = {1'b0, prod_reg} + RND;
        assign sh     = rs >> F;
        assign lim    = neg_reg[1] ? LIM_N : LIM_P;
        assign m      = (sh > lim) ? lim : sh;
        assign mneg   = ~m + ONE_P;
        assign p_next = neg_reg[1] ? mneg[W-1:0] : m[W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ll_reg   <= ll_next;
                lh_reg   <= lh_next;
                hl_reg   <= hl_next;
                hh_reg   <= hh_next;
                neg_reg  <= {neg_reg[0], aw[W-1] ^ bw[W-1]};
                prod_reg <= prod_next;
                p_reg    <= p_next;
            end
        end

        assign p[l*W +: W] = p_reg;
    end

endmodule

FILE: rtl/core/ewfj_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share
// one divisor. Gives round(a * 2^F / d) half away from zero, saturated.
// Setup, iteration and final rounding stages are all registered.
module ewfj_div #(
    parameter int W     = ewfj_pkg::WORD_BITS_DEF,
    parameter int F     = ewfj_pkg::FRAC_BITS_DEF,
    parameter int LANES = 1,
    parameter int SB    = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [LANES*W-1:0] num,
    input  logic [W-1:0]       den,
    input  logic [SB-1:0]      side_in,
    output logic               out_valid,
    output logic [LANES*W-1:0] quo,
    output logic [SB-1:0]      side_out
);

    localparam logic [W:0]   ONE_Q = 1;
    localparam logic [W:0]   LIM_P = (ONE_Q << (W - 1)) - ONE_Q;
    localparam logic [W:0]   LIM_N = ONE_Q << (W - 1);
    localparam logic [W-1:0] WMAX  = LIM_P[W-1:0];
    localparam logic [W-1:0] WMIN  = LIM_N[W-1:0];

    logic            vld_reg  [0:W];
    logic [SB-1:0]   side_reg [0:W];
    logic [W-1:0]    d_reg    [0:W];
    logic [W-1:0]    x_reg    [0:W][0:LANES-1];
    logic [W-1:0]    r_reg    [0:W][0:LANES-1];
    logic [W-1:0]    q_reg    [0:W][0:LANES-1];
    logic            neg_reg  [0:W][0:LANES-1];
    logic            ovf_reg  [0:W][0:LANES-1];
    logic            apos_reg [0:W][0:LANES-1];
    logic            aneg_reg [0:W][0:LANES-1];
    logic            vo_reg;
    logic [SB-1:0]   so_reg;
    logic [W-1:0]    dm;

    assign dm = den[W-1] ? (~den + 1'b1) : den;

    // setup stage: magnitudes, signs, upper partial remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]    <= dm;
            side_reg[0] <= side_in;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_setup
        logic [W-1:0] aw, am, r0;

        assign aw = num[l*W +: W];
        assign am = aw[W-1] ? (~aw + 1'b1) : aw;
        assign r0 = am >> (W - F);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[0][l]    <= am;
                r_reg[0][l]    <= r0;
                q_reg[0][l]    <= '0;
                neg_reg[0][l]  <= aw[W-1] ^ den[W-1];
                ovf_reg[0][l]  <= (r0 >= dm);
                apos_reg[0][l] <= !aw[W-1] && (aw != '0);
                aneg_reg[0][l] <= aw[W-1];
            end
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= W; k++)
    begin : g_iter
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic         nbit;
            logic         fits;
            logic [W:0]   trial, diff;
            logic [W-1:0] r_next, q_next;

            if (W - k >= F)
            begin : g_xbit
                assign nbit = x_reg[k-1][l][W-k-F];
            end
            else
            begin : g_zbit
                assign nbit = 1'b0;
            end

            assign trial  = {r_reg[k-1][l], nbit};
            assign diff   = trial - {1'b0, d_reg[k-1]};
            assign fits   = (trial >= {1'b0, d_reg[k-1]});
            assign r_next = fits ? diff[W-1:0] : trial[W-1:0];
            assign q_next = {q_reg[k-1][l][W-2:0], fits};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k][l]    <= x_reg[k-1][l];
                    r_reg[k][l]    <= r_next;
                    q_reg[k][l]    <= q_next;
                    neg_reg[k][l]  <= neg_reg[k-1][l];
                    ovf_reg[k][l]  <= ovf_reg[k-1][l];
                    apos_reg[k][l] <= apos_reg[k-1][l];
                    aneg_reg[k][l] <= aneg_reg[k-1][l];
                end
            end
        end
    end

    // final stage: round, saturate, sign, divide-by-zero handling
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vo_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            so_reg <= side_reg[W];
        end
    end

    assign out_valid = vo_reg;
    assign side_out  = so_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        logic         rnd;
        logic [W:0]   qr, lim, m, mneg;
        logic [W-1:0] res_next, res_reg;

        assign rnd  = ({r_reg[W][l], 1'b0} >= {1'b0, d_reg[W]});
        assign qr   = {1'b0, q_reg[W][l]} + {{W{1'b0}}, rnd};
        assign lim  = neg_reg[W][l] ? LIM_N : LIM_P;
        assign m    = (ovf_reg[W][l] || (qr > lim)) ? lim : qr;
        assign mneg = ~m + ONE_Q;

        always_comb
        begin
            if (d_reg[W] == '0)
            begin
                res_next = apos_reg[W][l] ? WMAX : (aneg_reg[W][l] ? WMIN : '0);
            end
            else
            begin
                res_next = neg_reg[W][l] ? mneg[W-1:0] : m[W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                res_reg <= res_next;
            end
        end

        assign quo[l*W +: W] = res_reg;
    end

endmodule

FILE: rtl/core/euler2d_wall_flux_jacobian_core.sv
// Channel  | Direction | Payload                                   | Handshake
// s_axis   | in        | tdata: normal_x, normal_y, density,       | tvalid/tready
//          |           |        momentum_x, momentum_y, total_energy|
// m_axis   | out       | tdata: flux, jac col0..col3; tuser: row,  | tvalid/tready
//          |           |        bad_density; tlast: last_row        |
// cfg      | in        | cfg_wr_data: gamma                        | cfg_wr_en
//
// Each request yields four result rows, one per cycle while m_axis_tready
// is high; the four-row output register takes no new item until its last
// row is taken. Data passes the two bit-per-stage dividers (velocity,
// then enthalpy) and the five multiplier banks in the chain.
// Reset clears all valid bits and loads gamma with 1.4.
// When the output register holds an unfinished item the whole pipeline
// freezes in place; nothing is dropped or repeated.
module euler2d_wall_flux_jacobian_core #(
    parameter int WORD_BITS = ewfj_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ewfj_pkg::FRAC_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    // normal_x, normal_y, density, momentum_x, momentum_y, total_energy
    input  logic [((6*WORD_BITS+7)/8)*8-1:0]               s_axis_tdata,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // flux_value, jac_col0, jac_col1, jac_col2, jac_col3
    output logic [((5*WORD_BITS+7)/8)*8-1:0]               m_axis_tdata,
    // row, bad_density
    output logic [2:0]                                     m_axis_tuser,
    output logic                                           m_axis_tlast,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    input  logic                                           cfg_wr_en,
    input  logic [ewfj_pkg::GAMMA_BITS-1:0]                cfg_wr_data
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int GB = ewfj_pkg::GAMMA_BITS;
    localparam int OUT_BITS = ((5 * W + 7) / 8) * 8;
    localparam logic [63:0] GAMMA_FULL = ((64'd7 << F) + 64'd2) / 64'd5;
    localparam logic [GB-1:0] GAMMA_RST = GAMMA_FULL[GB-1:0];

    typedef logic [W-1:0] word_t;

    localparam word_t ONE_W = word_t'(1) << F;
    localparam word_t WMAX  = (word_t'(1) << (W - 1)) - word_t'(1);
    localparam word_t WMIN  = word_t'(1) << (W - 1);

    typedef struct packed {
        word_t nx, ny, rho, mx, my, e;
        logic  bad;
    } d1_side_t;

    typedef struct packed {
        word_t nx, ny, rho, mx, my, u, v;
        logic  bad;
    } m1_side_t;

    typedef struct packed {
        word_t nx, ny, rho, mx, my, u, v, un, vel2, ge, r13, r22, unx, vny;
        logic  bad;
    } a1_t;

    typedef struct packed {
        word_t nx, ny, rho, ge, r13, r22, unx, vny, un;
        logic  bad;
    } m2_side_t;

    typedef struct packed {
        word_t nx, ny, rho, ge, r13, r22, unx, vny, un;
        word_t r00, r10, r20, uun, vun, hv2, r34;
        logic  bad;
    } m3_side_t;

    typedef struct packed {
        word_t nx, ny, rho, un, rh, r00, r10, r20, r34, hv2, unug, unvg;
        word_t r11, r21, r12, r13, r22, r23;
        logic  bad;
    } a2_t;

    typedef struct packed {
        word_t nx, ny, un, rh, r00, r10, r20, r34, hv2, unug, unvg;
        word_t r11, r21, r12, r13, r22, r23;
        logic  bad;
    } d2_side_t;

    typedef struct packed {
        word_t nx, ny, un, h, hv2, unug, unvg, r00, r10, r20, r34;
        word_t r11, r21, r12, r13, r22, r23;
        logic  bad;
    } m4_side_t;

    typedef struct packed {
        word_t nx, ny, un, t, r00, r10, r20, r34, r11, r21, r12, r13, r22, r23;
        word_t r30, r32, r33;
        logic  bad;
    } a3_t;

    typedef struct packed {
        word_t nx, ny, r00, r10, r20, r34, r11, r21, r12, r13, r22, r23;
        word_t r30, r32, r33;
        logic  bad;
    } m5_side_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            return s[W] ? WMIN : WMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic word_t sat_neg(word_t a);
        return (a == WMIN) ? WMAX : (~a + 1'b1);
    endfunction

    logic          pipe_adv;
    logic [GB-1:0] gamma_reg;
    word_t         g_w, gm1_reg, hgm1_reg, gm1_next, hgm1_next;

    // gamma register and the derived (gamma-1) and (gamma-1)/2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RST;
        end
        else if (cfg_wr_en)
        begin
            gamma_reg <= cfg_wr_data;
        end
    end

    assign g_w      = word_t'(gamma_reg);
    assign gm1_next = sat_sub(g_w, ONE_W);

    always_comb
    begin
        logic [W-1:0] mg;
        logic [W:0]   hm;
        mg = gm1_reg[W-1] ? (~gm1_reg + 1'b1) : gm1_reg;
        hm = ({1'b0, mg} + 1'b1) >> 1;
        hgm1_next = gm1_reg[W-1] ? (~hm[W-1:0] + 1'b1) : hm[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        gm1_reg  <= gm1_next;
        hgm1_reg <= hgm1_next;
    end

    // input unpack and velocity division
    d1_side_t d1_in, d1_out;
    logic     d1_vld;
    word_t    [1:0] d1_q;

    assign d1_in.nx  = s_axis_tdata[0*W +: W];
    assign d1_in.ny  = s_axis_tdata[1*W +: W];
    assign d1_in.rho = s_axis_tdata[2*W +: W];
    assign d1_in.mx  = s_axis_tdata[3*W +: W];
    assign d1_in.my  = s_axis_tdata[4*W +: W];
    assign d1_in.e   = s_axis_tdata[5*W +: W];
    assign d1_in.bad = d1_in.rho[W-1] || (d1_in.rho == '0);

    ewfj_div #(.W(W), .F(F), .LANES(2), .SB($bits(d1_side_t))) u_div_vel (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (s_axis_tvalid),
        .num      ({d1_in.my, d1_in.mx}),
        .den      (d1_in.rho),
        .side_in  (d1_in),
        .out_valid(d1_vld),
        .quo      (d1_q),
        .side_out (d1_out)
    );

    // products of velocity with normal and itself, gamma*E
    m1_side_t m1_in, m1_out;
    logic     m1_vld;
    word_t    [6:0] m1_p;

    assign m1_in.nx  = d1_out.nx;
    assign m1_in.ny  = d1_out.ny;
    assign m1_in.rho = d1_out.rho;
    assign m1_in.mx  = d1_out.mx;
    assign m1_in.my  = d1_out.my;
    assign m1_in.u   = d1_q[0];
    assign m1_in.v   = d1_q[1];
    assign m1_in.bad = d1_out.bad;

    ewfj_mul #(.W(W), .F(F), .LANES(7), .SB($bits(m1_side_t))) u_mul_1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (d1_vld),
        .a        ({d1_q[1], d1_q[0], g_w, d1_q[1], d1_q[0], d1_q[1], d1_q[0]}),
        .b        ({d1_out.nx, d1_out.ny, d1_out.e, d1_q[1], d1_q[0],
                    d1_out.ny, d1_out.nx}),
        .side_in  (m1_in),
        .out_valid(m1_vld),
        .p        (m1_p),
        .side_out (m1_out)
    );

    // normal velocity and squared speed
    a1_t  a1_next, a1_reg;
    logic a1_vld_reg;

    always_comb
    begin
        a1_next.nx   = m1_out.nx;
        a1_next.ny   = m1_out.ny;
        a1_next.rho  = m1_out.rho;
        a1_next.mx   = m1_out.mx;
        a1_next.my   = m1_out.my;
        a1_next.u    = m1_out.u;
        a1_next.v    = m1_out.v;
        a1_next.un   = sat_add(m1_p[0], m1_p[1]);
        a1_next.vel2 = sat_add(m1_p[2], m1_p[3]);
        a1_next.ge   = m1_p[4];
        a1_next.r13  = m1_p[5];
        a1_next.r22  = m1_p[6];
        a1_next.unx  = m1_p[0];
        a1_next.vny  = m1_p[1];
        a1_next.bad  = m1_out.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_vld_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            a1_vld_reg <= m1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            a1_reg <= a1_next;
        end
    end

    // flux rows 0..2, velocity products, rho*vel2, hgm1*vel2, gamma*un
    m2_side_t m2_in, m2_out;
    logic     m2_vld;
    word_t    [7:0] m2_p;

    assign m2_in.nx  = a1_reg.nx;
    assign m2_in.ny  = a1_reg.ny;
    assign m2_in.rho = a1_reg.rho;
    assign m2_in.ge  = a1_reg.ge;
    assign m2_in.r13 = a1_reg.r13;
    assign m2_in.r22 = a1_reg.r22;
    assign m2_in.unx = a1_reg.unx;
    assign m2_in.vny = a1_reg.vny;
    assign m2_in.un  = a1_reg.un;
    assign m2_in.bad = a1_reg.bad;

    ewfj_mul #(.W(W), .F(F), .LANES(8), .SB($bits(m2_side_t))) u_mul_2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (a1_vld_reg),
        .a        ({g_w, hgm1_reg, a1_reg.rho, a1_reg.v, a1_reg.u, a1_reg.un,
                    a1_reg.un, a1_reg.rho}),
        .b        ({a1_reg.un, a1_reg.vel2, a1_reg.vel2, a1_reg.un, a1_reg.un,
                    a1_reg.my, a1_reg.mx, a1_reg.un}),
        .side_in  (m2_in),
        .out_valid(m2_vld),
        .p        (m2_p),
        .side_out (m2_out)
    );

    // terms scaled by (gamma-1)
    m3_side_t m3_in, m3_out;
    logic     m3_vld;
    word_t    [2:0] m3_p;

    always_comb
    begin
        m3_in.nx  = m2_out.nx;
        m3_in.ny  = m2_out.ny;
        m3_in.rho = m2_out.rho;
        m3_in.ge  = m2_out.ge;
        m3_in.r13 = m2_out.r13;
        m3_in.r22 = m2_out.r22;
        m3_in.unx = m2_out.unx;
        m3_in.vny = m2_out.vny;
        m3_in.un  = m2_out.un;
        m3_in.r00 = m2_p[0];
        m3_in.r10 = m2_p[1];
        m3_in.r20 = m2_p[2];
        m3_in.uun = m2_p[3];
        m3_in.vun = m2_p[4];
        m3_in.hv2 = m2_p[6];
        m3_in.r34 = m2_p[7];
        m3_in.bad = m2_out.bad;
    end

    ewfj_mul #(.W(W), .F(F), .LANES(3), .SB($bits(m3_side_t))) u_mul_3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (m2_vld),
        .a        ({m2_p[4], m2_p[3], hgm1_reg}),
        .b        ({gm1_reg, gm1_reg, m2_p[5]}),
        .side_in  (m3_in),
        .out_valid(m3_vld),
        .p        (m3_p),
        .side_out (m3_out)
    );

    // rhoH and the sums of the momentum rows
    a2_t  a2_next, a2_reg;
    logic a2_vld_reg;

    always_comb
    begin
        a2_next.nx   = m3_out.nx;
        a2_next.ny   = m3_out.ny;
        a2_next.rho  = m3_out.rho;
        a2_next.un   = m3_out.un;
        a2_next.rh   = sat_sub(m3_out.ge, m3_p[0]);
        a2_next.r00  = m3_out.r00;
        a2_next.r10  = m3_out.r10;
        a2_next.r20  = m3_out.r20;
        a2_next.r34  = m3_out.r34;
        a2_next.hv2  = m3_out.hv2;
        a2_next.unug = m3_p[1];
        a2_next.unvg = m3_p[2];
        a2_next.r11  = sat_neg(m3_out.uun);
        a2_next.r21  = sat_neg(m3_out.vun);
        a2_next.r12  = sat_add(m3_out.un, m3_out.unx);
        a2_next.r13  = m3_out.r13;
        a2_next.r22  = m3_out.r22;
        a2_next.r23  = sat_add(m3_out.un, m3_out.vny);
        a2_next.bad  = m3_out.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a2_vld_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            a2_vld_reg <= m3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            a2_reg <= a2_next;
        end
    end

    // enthalpy h = rhoH / rho
    d2_side_t d2_in, d2_out;
    logic     d2_vld;
    word_t    d2_h;

    always_comb
    begin
        d2_in.nx   = a2_reg.nx;
        d2_in.ny   = a2_reg.ny;
        d2_in.un   = a2_reg.un;
        d2_in.rh   = a2_reg.rh;
        d2_in.r00  = a2_reg.r00;
        d2_in.r10  = a2_reg.r10;
        d2_in.r20  = a2_reg.r20;
        d2_in.r34  = a2_reg.r34;
        d2_in.hv2  = a2_reg.hv2;
        d2_in.unug = a2_reg.unug;
        d2_in.unvg = a2_reg.unvg;
        d2_in.r11  = a2_reg.r11;
        d2_in.r21  = a2_reg.r21;
        d2_in.r12  = a2_reg.r12;
        d2_in.r13  = a2_reg.r13;
        d2_in.r22  = a2_reg.r22;
        d2_in.r23  = a2_reg.r23;
        d2_in.bad  = a2_reg.bad;
    end

    ewfj_div #(.W(W), .F(F), .LANES(1), .SB($bits(d2_side_t))) u_div_enth (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (a2_vld_reg),
        .num      (a2_reg.rh),
        .den      (a2_reg.rho),
        .side_in  (d2_in),
        .out_valid(d2_vld),
        .quo      (d2_h),
        .side_out (d2_out)
    );

    // energy flux and h times normal
    m4_side_t m4_in, m4_out;
    logic     m4_vld;
    word_t    [2:0] m4_p;

    always_comb
    begin
        m4_in.nx   = d2_out.nx;
        m4_in.ny   = d2_out.ny;
        m4_in.un   = d2_out.un;
        m4_in.h    = d2_h;
        m4_in.hv2  = d2_out.hv2;
        m4_in.unug = d2_out.unug;
        m4_in.unvg = d2_out.unvg;
        m4_in.r00  = d2_out.r00;
        m4_in.r10  = d2_out.r10;
        m4_in.r20  = d2_out.r20;
        m4_in.r34  = d2_out.r34;
        m4_in.r11  = d2_out.r11;
        m4_in.r21  = d2_out.r21;
        m4_in.r12  = d2_out.r12;
        m4_in.r13  = d2_out.r13;
        m4_in.r22  = d2_out.r22;
        m4_in.r23  = d2_out.r23;
        m4_in.bad  = d2_out.bad;
    end

    ewfj_mul #(.W(W), .F(F), .LANES(3), .SB($bits(m4_side_t))) u_mul_4 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (d2_vld),
        .a        ({d2_h, d2_h, d2_out.un}),
        .b        ({d2_out.ny, d2_out.nx, d2_out.rh}),
        .side_in  (m4_in),
        .out_valid(m4_vld),
        .p        (m4_p),
        .side_out (m4_out)
    );

    // energy row differences
    a3_t  a3_next, a3_reg;
    logic a3_vld_reg;

    always_comb
    begin
        a3_next.nx  = m4_out.nx;
        a3_next.ny  = m4_out.ny;
        a3_next.un  = m4_out.un;
        a3_next.t   = sat_sub(m4_out.hv2, m4_out.h);
        a3_next.r00 = m4_out.r00;
        a3_next.r10 = m4_out.r10;
        a3_next.r20 = m4_out.r20;
        a3_next.r34 = m4_out.r34;
        a3_next.r11 = m4_out.r11;
        a3_next.r21 = m4_out.r21;
        a3_next.r12 = m4_out.r12;
        a3_next.r13 = m4_out.r13;
        a3_next.r22 = m4_out.r22;
        a3_next.r23 = m4_out.r23;
        a3_next.r30 = m4_p[0];
        a3_next.r32 = sat_sub(m4_p[1], m4_out.unug);
        a3_next.r33 = sat_sub(m4_p[2], m4_out.unvg);
        a3_next.bad = m4_out.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a3_vld_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            a3_vld_reg <= m4_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            a3_reg <= a3_next;
        end
    end

    // last Jacobian entry un * (hgm1*vel2 - h)
    m5_side_t m5_in, m5_out;
    logic     m5_vld;
    word_t    m5_p;

    always_comb
    begin
        m5_in.nx  = a3_reg.nx;
        m5_in.ny  = a3_reg.ny;
        m5_in.r00 = a3_reg.r00;
        m5_in.r10 = a3_reg.r10;
        m5_in.r20 = a3_reg.r20;
        m5_in.r34 = a3_reg.r34;
        m5_in.r11 = a3_reg.r11;
        m5_in.r21 = a3_reg.r21;
        m5_in.r12 = a3_reg.r12;
        m5_in.r13 = a3_reg.r13;
        m5_in.r22 = a3_reg.r22;
        m5_in.r23 = a3_reg.r23;
        m5_in.r30 = a3_reg.r30;
        m5_in.r32 = a3_reg.r32;
        m5_in.r33 = a3_reg.r33;
        m5_in.bad = a3_reg.bad;
    end

    ewfj_mul #(.W(W), .F(F), .LANES(1), .SB($bits(m5_side_t))) u_mul_5 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_adv),
        .in_valid (a3_vld_reg),
        .a        (a3_reg.un),
        .b        (a3_reg.t),
        .side_in  (m5_in),
        .out_valid(m5_vld),
        .p        (m5_p),
        .side_out (m5_out)
    );

    // output register: four flux/Jacobian rows, one per cycle on tready
    word_t      res_next [0:3][0:4];
    word_t      res_reg  [0:3][0:4];
    logic       out_vld_reg;
    logic       bad_reg;
    logic [1:0] row_reg;

    always_comb
    begin
        res_next[0][0] = m5_out.r00;
        res_next[0][1] = '0;
        res_next[0][2] = m5_out.nx;
        res_next[0][3] = m5_out.ny;
        res_next[0][4] = '0;
        res_next[1][0] = m5_out.r10;
        res_next[1][1] = m5_out.r11;
        res_next[1][2] = m5_out.r12;
        res_next[1][3] = m5_out.r13;
        res_next[1][4] = '0;
        res_next[2][0] = m5_out.r20;
        res_next[2][1] = m5_out.r21;
        res_next[2][2] = m5_out.r22;
        res_next[2][3] = m5_out.r23;
        res_next[2][4] = '0;
        res_next[3][0] = m5_out.r30;
        res_next[3][1] = m5_p;
        res_next[3][2] = m5_out.r32;
        res_next[3][3] = m5_out.r33;
        res_next[3][4] = m5_out.r34;
        // bad density forces every value to zero
        if (m5_out.bad)
        begin
            for (int k = 0; k < 4; k++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    res_next[k][j] = '0;
                end
            end
        end
    end

    assign pipe_adv = !out_vld_reg || (m_axis_tready && (row_reg == ewfj_pkg::ROW_ENERGY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            row_reg     <= ewfj_pkg::ROW_MASS;
        end
        else if (pipe_adv)
        begin
            out_vld_reg <= m5_vld;
            row_reg     <= ewfj_pkg::ROW_MASS;
        end
        else if (m_axis_tready)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            res_reg <= res_next;
            bad_reg <= m5_out.bad;
        end
    end

    assign s_axis_tready = pipe_adv;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tlast  = (row_reg == ewfj_pkg::ROW_ENERGY);
    assign m_axis_tuser  = {bad_reg, row_reg};
    assign m_axis_tdata  = OUT_BITS'({res_reg[row_reg][4], res_reg[row_reg][3],
                                      res_reg[row_reg][2], res_reg[row_reg][1],
                                      res_reg[row_reg][0]});

    // rows of one item go out in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && m_axis_tready && (row_reg != ewfj_pkg::ROW_ENERGY)
        |=> out_vld_reg && (row_reg == $past(row_reg) + 2'd1))
    else $error("result row sequence broken");

    // a bad density gives all-zero values
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && bad_reg |-> (m_axis_tdata == '0))
    else $error("nonzero values with bad density");

    // no new request while an item is mid-way through its rows
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (row_reg != ewfj_pkg::ROW_ENERGY) |-> !s_axis_tready)
    else $error("pipeline advanced during row output");

    // a stalled pipeline holds its valid bits in place
    assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_adv |=> $stable(m5_vld) && $stable(a3_vld_reg))
    else $error("pipeline moved while stalled");

endmodule
